FILE: design/vpp_pkg.sv
// Shared types, widths and constants for the vertex perspective projection pipeline.
// No dependencies; every design file imports this package.
package vpp_pkg;

    // Screen geometry
    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 160;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_POSITION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_RIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_UP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_FORWARD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT      = 3'd4;

    localparam int NEAR_W = 15;

    typedef logic [CFG_DATA_W-1:0] vec_t;

    localparam vec_t CAMERA_POSITION_RST = 48'h0000_0000_0000;
    localparam vec_t CAMERA_RIGHT_RST    = 48'h0000_0000_4000;
    localparam vec_t CAMERA_UP_RST       = 48'h0000_4000_0000;
    localparam vec_t CAMERA_FORWARD_RST  = 48'h4000_0000_0000;
    localparam logic [NEAR_W-1:0] NEAR_LIMIT_RST = 15'd26;

    // Datapath widths
    localparam int LANE_W = 16;                    // one packed coordinate
    localparam int D_W    = LANE_W + 1;            // point minus camera position
    localparam int PROD_W = D_W + LANE_W;          // Q8.8 * Q2.14 product, scale 2^22
    localparam int V_W    = PROD_W + 2;            // sum of three products
    localparam int SUMX_W = V_W + 1;               // vx + vz

    localparam int HH = SCREEN_HEIGHT * SCREEN_HEIGHT;
    localparam int WW = SCREEN_WIDTH * SCREEN_WIDTH;
    localparam int H2 = 2 * SCREEN_HEIGHT;

    localparam int W_W  = $clog2(SCREEN_WIDTH + 1) + 1;
    localparam int HH_W = $clog2(HH + 1) + 1;
    localparam int WW_W = $clog2(WW + 1) + 1;
    localparam int H2_W = $clog2(H2 + 1) + 1;

    localparam int NUMX_W = SUMX_W + W_W;
    localparam int PY_W   = V_W + ((HH_W > WW_W) ? HH_W : WW_W);
    localparam int NUMY_W = PY_W + 1;
    localparam int DENX_W = V_W + 1;
    localparam int DENY_W = V_W + H2_W;

    localparam int DIV_W = (NUMY_W > NUMX_W) ?
                           ((NUMY_W > DENY_W) ? NUMY_W : DENY_W) :
                           ((NUMX_W > DENY_W) ? NUMX_W : DENY_W);

    localparam logic signed [W_W-1:0]  W_S  = W_W'(SCREEN_WIDTH);
    localparam logic signed [HH_W-1:0] HH_S = HH_W'(HH);
    localparam logic signed [WW_W-1:0] WW_S = WW_W'(WW);
    localparam logic signed [H2_W-1:0] H2_S = H2_W'(H2);

    // Quotient and pipeline depth
    localparam int Q_W      = 16;
    localparam int XFORM_LAT = 3;
    localparam int PREP_LAT  = 3;
    localparam int DIV_LAT   = Q_W + 2;
    localparam int PIPE_LAT  = XFORM_LAT + PREP_LAT + DIV_LAT;

    localparam logic signed [Q_W-1:0] INT16_MAX = 16'sh7FFF;
    localparam logic signed [Q_W-1:0] INT16_MIN = 16'sh8000;
    localparam logic signed [Q_W-1:0] OFF_SCREEN = 16'shFFFF;
    localparam logic [Q_W-1:0] NEG_LIMIT = 16'h8000;

    typedef struct packed {
        logic signed [LANE_W-1:0] point_x;
        logic signed [LANE_W-1:0] point_y;
        logic signed [LANE_W-1:0] point_z;
    } in_item_t;

    typedef struct packed {
        logic signed [Q_W-1:0] screen_x;
        logic signed [Q_W-1:0] screen_y;
        logic                  behind_camera;
    } out_item_t;

    typedef struct packed {
        logic                  valid;
        logic signed [V_W-1:0] vx;
        logic signed [V_W-1:0] vy;
        logic signed [V_W-1:0] vz;
    } xform_t;

    typedef struct packed {
        logic             valid;
        logic             behind;
        logic             neg;
        logic [DIV_W-1:0] mag;
        logic [DIV_W-1:0] den;
    } div_in_t;

    typedef struct packed {
        logic                  valid;
        logic                  behind;
        logic signed [Q_W-1:0] value;
    } div_out_t;

endpackage

FILE: design/vpp_xform.sv
// World-to-camera transform: subtract camera position, nine products, three dot sums.
// Three register stages. Depends on vpp_pkg.
module vpp_xform (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid,
    input  vpp_pkg::in_item_t point,
    input  vpp_pkg::vec_t    camera_position,
    input  vpp_pkg::vec_t    camera_right,
    input  vpp_pkg::vec_t    camera_up,
    input  vpp_pkg::vec_t    camera_forward,
    output vpp_pkg::xform_t  xf
);
    import vpp_pkg::*;

    logic signed [LANE_W-1:0] pt [3];
    vec_t                     axis [3];

    logic                     s0_vld_reg, s1_vld_reg, s2_vld_reg;
    logic signed [D_W-1:0]    d_reg [3];
    logic signed [D_W-1:0]    d_next [3];
    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic signed [PROD_W-1:0] prod_next [3][3];
    logic signed [V_W-1:0]    v_reg [3];
    logic signed [V_W-1:0]    v_next [3];

    always_comb
    begin
        pt[0]   = point.point_x;
        pt[1]   = point.point_y;
        pt[2]   = point.point_z;
        axis[0] = camera_right;
        axis[1] = camera_up;
        axis[2] = camera_forward;
        for (int k = 0; k < 3; k++)
        begin
            d_next[k] = D_W'(pt[k]) - D_W'($signed(camera_position[LANE_W*k +: LANE_W]));
        end
        for (int a = 0; a < 3; a++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_next[a][k] = PROD_W'(d_reg[k])
                                * PROD_W'($signed(axis[a][LANE_W*k +: LANE_W]));
            end
        end
        for (int a = 0; a < 3; a++)
        begin
            v_next[a] = V_W'(prod_reg[a][0]) + V_W'(prod_reg[a][1]) + V_W'(prod_reg[a][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= valid;
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg     <= d_next;
        prod_reg  <= prod_next;
        v_reg     <= v_next;
    end

    assign xf = '{valid: s2_vld_reg, vx: v_reg[0], vy: v_reg[1], vz: v_reg[2]};

endmodule

FILE: design/vpp_prep.sv
// Builds signed numerators and positive denominators for both screen axes,
// flags points nearer than the near limit. Three register stages. Depends on vpp_pkg.
module vpp_prep (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [vpp_pkg::NEAR_W-1:0]  near_limit,
    input  vpp_pkg::xform_t             xf,
    output vpp_pkg::div_in_t            div_x,
    output vpp_pkg::div_in_t            div_y
);
    import vpp_pkg::*;

    // stage 3
    logic                     s3_vld_reg, s3_bhd_reg, s3_bhd_next;
    logic signed [SUMX_W-1:0] sumx_reg, sumx_next;
    logic signed [PY_W-1:0]   pyh_reg, pyh_next, pyw_reg, pyw_next;
    logic [DENX_W-1:0]        denx3_reg, denx3_next;
    logic [DENY_W-1:0]        deny3_reg, deny3_next;
    logic [V_W-1:0]           near_ext;

    // stage 4
    logic                     s4_vld_reg, s4_bhd_reg;
    logic signed [NUMX_W-1:0] numx_reg, numx_next;
    logic signed [NUMY_W-1:0] numy_reg, numy_next;
    logic [DENX_W-1:0]        denx4_reg;
    logic [DENY_W-1:0]        deny4_reg;

    // stage 5
    logic                     s5_vld_reg, s5_bhd_reg;
    logic                     negx_reg, negy_reg;
    logic signed [DIV_W-1:0]  extx, exty;
    logic [DIV_W-1:0]         magx_reg, magx_next, magy_reg, magy_next;
    logic [DIV_W-1:0]         denx5_reg, deny5_reg;

    always_comb
    begin
        // near limit is unsigned Q7.8; camera depth carries scale 2^22
        near_ext    = V_W'({near_limit, 14'b0});
        s3_bhd_next = (xf.vz <= V_W'(0)) || (xf.vz < $signed(near_ext));
        sumx_next   = SUMX_W'(xf.vx) + SUMX_W'(xf.vz);
        pyh_next    = PY_W'(xf.vz) * PY_W'(HH_S);
        pyw_next    = PY_W'(xf.vy) * PY_W'(WW_S);
        denx3_next  = DENX_W'({xf.vz, 1'b0});
        deny3_next  = DENY_W'(DENY_W'(xf.vz) * DENY_W'(H2_S));

        numx_next   = NUMX_W'(sumx_reg) * NUMX_W'(W_S);
        numy_next   = NUMY_W'(pyh_reg) - NUMY_W'(pyw_reg);

        extx        = DIV_W'(numx_reg);
        exty        = DIV_W'(numy_reg);
        magx_next   = numx_reg[NUMX_W-1] ? DIV_W'(-extx) : DIV_W'(extx);
        magy_next   = numy_reg[NUMY_W-1] ? DIV_W'(-exty) : DIV_W'(exty);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else
        begin
            s3_vld_reg <= xf.valid;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_bhd_reg <= s3_bhd_next;
        sumx_reg   <= sumx_next;
        pyh_reg    <= pyh_next;
        pyw_reg    <= pyw_next;
        denx3_reg  <= denx3_next;
        deny3_reg  <= deny3_next;

        s4_bhd_reg <= s3_bhd_reg;
        numx_reg   <= numx_next;
        numy_reg   <= numy_next;
        denx4_reg  <= denx3_reg;
        deny4_reg  <= deny3_reg;

        s5_bhd_reg <= s4_bhd_reg;
        negx_reg   <= numx_reg[NUMX_W-1];
        negy_reg   <= numy_reg[NUMY_W-1];
        magx_reg   <= magx_next;
        magy_reg   <= magy_next;
        denx5_reg  <= DIV_W'(denx4_reg);
        deny5_reg  <= DIV_W'(deny4_reg);
    end

    assign div_x = '{valid: s5_vld_reg, behind: s5_bhd_reg, neg: negx_reg,
                     mag: magx_reg, den: denx5_reg};
    assign div_y = '{valid: s5_vld_reg, behind: s5_bhd_reg, neg: negy_reg,
                     mag: magy_reg, den: deny5_reg};

endmodule

FILE: design/vpp_div.sv
// Pipelined restoring divider: one quotient bit per stage, truncation toward zero,
// int16 saturation and the behind-camera override. Depends on vpp_pkg.
module vpp_div (
    input  logic              clk,
    input  logic              rst_n,
    input  vpp_pkg::div_in_t  din,
    output vpp_pkg::div_out_t dout
);
    import vpp_pkg::*;

    localparam int REM_W = DIV_W + Q_W;

    logic                  vld_reg [Q_W+1];
    logic                  bhd_reg [Q_W+1];
    logic                  neg_reg [Q_W+1];
    logic                  ovf_reg [Q_W+1];
    logic [DIV_W-1:0]      rem_reg [Q_W+1];
    logic [DIV_W-1:0]      den_reg [Q_W+1];
    logic [Q_W-1:0]        quo_reg [Q_W+1];

    logic                  ovf_in;
    logic [REM_W:0]        trial [1:Q_W];
    logic [DIV_W-1:0]      rem_next [1:Q_W];
    logic [Q_W-1:0]        quo_next [1:Q_W];

    logic                  out_vld_reg, out_bhd_reg;
    logic signed [Q_W-1:0] out_val_reg, out_val_next;
    logic [Q_W-1:0]        q_fin;

    always_comb
    begin
        // quotient of 2^16 or more saturates either way
        ovf_in = {{Q_W{1'b0}}, din.mag} >= {din.den, {Q_W{1'b0}}};
        for (int k = 1; k <= Q_W; k++)
        begin
            trial[k] = {1'b0, {Q_W{1'b0}}, rem_reg[k-1]}
                     - {1'b0, ({{Q_W{1'b0}}, den_reg[k-1]} << (Q_W - k))};
            if (!trial[k][REM_W])
            begin
                rem_next[k] = trial[k][DIV_W-1:0];
                quo_next[k] = quo_reg[k-1] | (Q_W'(1) << (Q_W - k));
            end
            else
            begin
                rem_next[k] = rem_reg[k-1];
                quo_next[k] = quo_reg[k-1];
            end
        end

        q_fin = quo_reg[Q_W];
        priority if (bhd_reg[Q_W])
            out_val_next = OFF_SCREEN;
        else if (neg_reg[Q_W] && (ovf_reg[Q_W] || (q_fin > NEG_LIMIT)))
            out_val_next = INT16_MIN;
        else if (neg_reg[Q_W])
            out_val_next = -$signed(q_fin);
        else if (ovf_reg[Q_W] || q_fin[Q_W-1])
            out_val_next = INT16_MAX;
        else
            out_val_next = $signed(q_fin);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= Q_W; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= din.valid;
            for (int k = 1; k <= Q_W; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            out_vld_reg <= vld_reg[Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        bhd_reg[0] <= din.behind;
        neg_reg[0] <= din.neg;
        ovf_reg[0] <= ovf_in;
        rem_reg[0] <= din.mag;
        den_reg[0] <= din.den;
        quo_reg[0] <= '0;
        for (int k = 1; k <= Q_W; k++)
        begin
            bhd_reg[k] <= bhd_reg[k-1];
            neg_reg[k] <= neg_reg[k-1];
            ovf_reg[k] <= ovf_reg[k-1];
            den_reg[k] <= den_reg[k-1];
            rem_reg[k] <= rem_next[k];
            quo_reg[k] <= quo_next[k];
        end
        out_bhd_reg <= bhd_reg[Q_W];
        out_val_reg <= out_val_next;
    end

    assign dout = '{valid: out_vld_reg, behind: out_bhd_reg, value: out_val_reg};

    a_div_valid_kept: assert property (@(posedge clk) disable iff (!rst_n)
        din.valid |-> ##(Q_W + 2) out_vld_reg)
        else $error("divider valid lost");

    a_div_valid_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !din.valid |-> ##(Q_W + 2) !out_vld_reg)
        else $error("divider valid invented");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[Q_W] && !bhd_reg[Q_W] && !ovf_reg[Q_W] |-> rem_reg[Q_W] < den_reg[Q_W])
        else $error("divider remainder not below divisor");

endmodule

FILE: design/vertex_perspective_projection.sv
// Top level: configuration registers, camera transform, operand prep and two dividers.
// Depends on vpp_pkg, vpp_xform, vpp_prep and vpp_div.
//
// Projects one signed Q8.8 world point per clock to a screen pixel. A point is taken
// whenever start is high; busy is always low, so a new point may follow every cycle.
// Each point yields exactly one result, shown on result for one cycle with done high;
// results leave in the order points came in and cannot be held off. Each point passes
// through six transform and operand stages, then the two 16-stage restoring dividers
// (one quotient bit per stage, behind one input register) and one saturation stage.
// Camera registers are written through cfg_write_en/cfg_index/cfg_data and must only
// change while no transaction is in flight. Points nearer than near_limit come out
// as -1,-1 with behind_camera set.
module vertex_perspective_projection (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  vpp_pkg::in_item_t              point,
    output logic                           done,
    output vpp_pkg::out_item_t             result,
    input  logic                           cfg_write_en,
    input  logic [vpp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vpp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import vpp_pkg::*;

    vec_t              position_reg, right_reg, up_reg, forward_reg;
    logic [NEAR_W-1:0] near_reg;

    xform_t            xf;
    div_in_t           div_x_in, div_y_in;
    div_out_t          div_x_out, div_y_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= CAMERA_POSITION_RST;
            right_reg    <= CAMERA_RIGHT_RST;
            up_reg       <= CAMERA_UP_RST;
            forward_reg  <= CAMERA_FORWARD_RST;
            near_reg     <= NEAR_LIMIT_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_CAMERA_POSITION: position_reg <= cfg_data;
                CFG_CAMERA_RIGHT:    right_reg    <= cfg_data;
                CFG_CAMERA_UP:       up_reg       <= cfg_data;
                CFG_CAMERA_FORWARD:  forward_reg  <= cfg_data;
                CFG_NEAR_LIMIT:      near_reg     <= cfg_data[NEAR_W-1:0];
                default:             ;
            endcase
        end
    end

    assign busy = 1'b0;

    vpp_xform u_xform (
        .clk             (clk),
        .rst_n           (rst_n),
        .valid           (start && !busy),
        .point           (point),
        .camera_position (position_reg),
        .camera_right    (right_reg),
        .camera_up       (up_reg),
        .camera_forward  (forward_reg),
        .xf              (xf)
    );

    vpp_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .near_limit (near_reg),
        .xf         (xf),
        .div_x      (div_x_in),
        .div_y      (div_y_in)
    );

    vpp_div u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (div_x_in),
        .dout  (div_x_out)
    );

    vpp_div u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (div_y_in),
        .dout  (div_y_out)
    );

    assign done   = div_x_out.valid;
    assign result = '{screen_x: div_x_out.value, screen_y: div_y_out.value,
                      behind_camera: div_x_out.behind};

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (div_x_out.valid == div_y_out.valid)
        && (!div_x_out.valid || (div_x_out.behind == div_y_out.behind)))
        else $error("x and y lanes out of step");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LAT done)
        else $error("accepted transaction produced no result strobe");

    a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##PIPE_LAT !done)
        else $error("result strobe without accepted transaction");

endmodule

FILE: tb/pixel_checker.sv
`timescale 1ns / 1ps
// Checker for the projection block: watches point, result and camera register traffic,
// predicts each pixel from its own copy of the camera and compares. Depends on vpp_pkg.
module pixel_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  vpp_pkg::in_item_t              point,
    input  logic                           done,
    input  vpp_pkg::out_item_t             result,
    input  logic                           cfg_write_en,
    input  logic [vpp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vpp_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             pending,
    output int                             mismatches
);
    import vpp_pkg::*;

    vec_t              cam_position;
    vec_t              cam_right;
    vec_t              cam_up;
    vec_t              cam_forward;
    logic [NEAR_W-1:0] near_depth;

    out_item_t expected_pixels[$];

    function automatic longint lane_of(vec_t v, int k);
        logic signed [LANE_W-1:0] s;
        s = v[LANE_W*k +: LANE_W];
        return longint'(s);
    endfunction

    function automatic logic signed [Q_W-1:0] clamp16(longint v);
        if (v > 32767)
            return INT16_MAX;
        if (v < -32768)
            return INT16_MIN;
        return v[Q_W-1:0];
    endfunction

    // camera-space coordinates carry a scale of 2^22 (Q8.8 times Q2.14)
    function automatic out_item_t project_point(in_item_t p);
        longint    d[3];
        longint    vx;
        longint    vy;
        longint    vz;
        longint    num;
        longint    den;
        out_item_t r;
        d[0] = longint'(p.point_x) - lane_of(cam_position, 0);
        d[1] = longint'(p.point_y) - lane_of(cam_position, 1);
        d[2] = longint'(p.point_z) - lane_of(cam_position, 2);
        vx = d[0] * lane_of(cam_right, 0) + d[1] * lane_of(cam_right, 1)
           + d[2] * lane_of(cam_right, 2);
        vy = d[0] * lane_of(cam_up, 0) + d[1] * lane_of(cam_up, 1)
           + d[2] * lane_of(cam_up, 2);
        vz = d[0] * lane_of(cam_forward, 0) + d[1] * lane_of(cam_forward, 1)
           + d[2] * lane_of(cam_forward, 2);
        if (vz <= 0 || vz < (longint'(near_depth) << 14)) begin
            r.screen_x      = OFF_SCREEN;
            r.screen_y      = OFF_SCREEN;
            r.behind_camera = 1'b1;
            return r;
        end
        num = longint'(SCREEN_WIDTH) * (vx + vz);
        den = 2 * vz;
        r.screen_x = clamp16(num / den);
        num = longint'(SCREEN_HEIGHT) * longint'(SCREEN_HEIGHT) * vz
            - longint'(SCREEN_WIDTH) * longint'(SCREEN_WIDTH) * vy;
        den = 2 * longint'(SCREEN_HEIGHT) * vz;
        r.screen_y = clamp16(num / den);
        r.behind_camera = 1'b0;
        return r;
    endfunction

    function automatic int field_differs(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n) begin : track
        out_item_t want;
        int        errs;
        if (!rst_n) begin
            cam_position <= CAMERA_POSITION_RST;
            cam_right    <= CAMERA_RIGHT_RST;
            cam_up       <= CAMERA_UP_RST;
            cam_forward  <= CAMERA_FORWARD_RST;
            near_depth   <= NEAR_LIMIT_RST;
            expected_pixels.delete();
            pending    <= 0;
            mismatches <= 0;
        end
        else begin
            if (cfg_write_en) begin
                case (cfg_index)
                    CFG_CAMERA_POSITION: cam_position <= cfg_data;
                    CFG_CAMERA_RIGHT:    cam_right    <= cfg_data;
                    CFG_CAMERA_UP:       cam_up       <= cfg_data;
                    CFG_CAMERA_FORWARD:  cam_forward  <= cfg_data;
                    CFG_NEAR_LIMIT:      near_depth   <= cfg_data[NEAR_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                expected_pixels.push_back(project_point(point));
            if (done) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected result %0d,%0d,%0b", $time,
                             result.screen_x, result.screen_y, result.behind_camera);
                    mismatches <= mismatches + 1;
                end
                else begin
                    want = expected_pixels.pop_front();
                    errs = field_differs("screen_x", longint'(want.screen_x),
                                         longint'(result.screen_x))
                         + field_differs("screen_y", longint'(want.screen_y),
                                         longint'(result.screen_y))
                         + field_differs("behind_camera", longint'(want.behind_camera),
                                         longint'(result.behind_camera));
                    if (errs != 0)
                        mismatches <= mismatches + 1;
                end
            end
            pending <= expected_pixels.size();
        end
    end

endmodule

FILE: tb/vertex_perspective_projection_test.sv
`timescale 1ns / 1ps
// Testbench top for the projection block: clock, reset, camera and point stimulus, verdict.
// Depends on vpp_pkg, vertex_perspective_projection and pixel_checker.
module vertex_perspective_projection_test;
    import vpp_pkg::*;

    localparam int CYCLE_LIMIT      = 100000;
    localparam int RANDOM_PHASES    = 10;
    localparam int POINTS_PER_PHASE = 65;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 3'd5;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  start        = 1'b0;
    logic                  busy;
    in_item_t              point        = '0;
    logic                  done;
    out_item_t             result;
    logic                  cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    int   pending;
    int   mismatches;
    int   cycle_count    = 0;
    int   points_sent    = 0;
    int   settings_used  = 0;
    bit   gaps_on        = 1'b1;
    vec_t cam_pos        = CAMERA_POSITION_RST;

    vertex_perspective_projection DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .point        (point),
        .done         (done),
        .result       (result),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    pixel_checker pixel_watch (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .point        (point),
        .done         (done),
        .result       (result),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pending      (pending),
        .mismatches   (mismatches)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic vec_t axis_vec(int axis, bit neg);
        vec_t v;
        v = '0;
        v[LANE_W*axis +: LANE_W] = neg ? 16'hC000 : 16'h4000;
        return v;
    endfunction

    // start stays high across back-to-back transactions; it drops only for a gap or in drain()
    task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic signed [15:0] z);
        start <= 1'b1;
        point <= '{point_x: x, point_y: y, point_z: z};
        do
            @(posedge clk);
        while (busy);
        points_sent++;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    // mostly points within a few units of the camera, so depth and screen range vary
    task automatic send_random_point();
        logic signed [15:0] c[3];
        int                 mode;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 3; k++) begin
            if (mode < 3)
                c[k] = 16'($urandom);
            else
                c[k] = cam_pos[LANE_W*k +: LANE_W] + 16'($urandom_range(0, 4095)) - 16'd2048;
        end
        send_point(c[0], c[1], c[2]);
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input vec_t data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
    endtask

    task automatic set_camera(input vec_t pos, input vec_t rgt, input vec_t upv,
                              input vec_t fwd, input vec_t near_data);
        write_reg(CFG_CAMERA_POSITION, pos);
        write_reg(CFG_CAMERA_RIGHT, rgt);
        write_reg(CFG_CAMERA_UP, upv);
        write_reg(CFG_CAMERA_FORWARD, fwd);
        write_reg(CFG_NEAR_LIMIT, near_data);
        cfg_write_en <= 1'b0;
        cam_pos = pos;
        settings_used++;
    endtask

    initial
    begin : stimulus
        vec_t pos;
        int   fwd_axis;
        bit   sane;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset camera: identity axes, near limit just above 0.1
        settings_used = 1;
        send_point(16'sd0, 16'sd0, 16'sd0);
        send_point(16'sd0, 16'sd0, 16'sd25);
        send_point(16'sd0, 16'sd0, 16'sd26);
        send_point(16'sd0, 16'sd0, 16'sd32767);
        send_point(16'sd32767, 16'sd32767, 16'sd26);
        send_point(-16'sd32768, -16'sd32768, 16'sd26);
        send_point(-16'sd32768, -16'sd32768, -16'sd32768);
        send_point(16'sd32767, 16'sd32767, 16'sd32767);
        send_point(-16'sd32768, 16'sd32767, 16'sd32767);
        send_point(16'sd21845, -16'sd21846, 16'sd300);
        drain();

        // zero near limit: zero and negative depth still count as behind
        set_camera(CAMERA_POSITION_RST, CAMERA_RIGHT_RST, CAMERA_UP_RST,
                   CAMERA_FORWARD_RST, 48'hFFFF_FFFF_8000);
        send_point(16'sd0, 16'sd0, 16'sd0);
        send_point(16'sd0, 16'sd0, 16'sd1);
        send_point(16'sd0, 16'sd0, -16'sd1);
        send_point(-16'sd1, 16'sd1, 16'sd1);
        send_point(16'sd256, -16'sd256, 16'sd2);
        drain();

        // extreme lanes everywhere, widest point-minus-camera difference, max near limit
        set_camera(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h7FFF_8000_7FFF,
                   48'h7FFF_7FFF_7FFF, 48'h0000_0000_7FFF);
        send_point(16'sd32767, 16'sd32767, 16'sd32767);
        send_point(-16'sd32768, -16'sd32768, -16'sd32768);
        send_point(16'sd32767, -16'sd32768, 16'sd32767);
        send_point(16'sd0, 16'sd0, 16'sd0);
        drain();

        // writes to unused indexes must leave the camera alone
        write_reg(CFG_FIRST_UNUSED + 3'($urandom_range(0, 2)), vec_t'({$urandom, $urandom}));
        cfg_write_en <= 1'b0;
        send_point(16'sd1000, -16'sd1000, 16'sd32767);
        send_point(-16'sd5, 16'sd5, 16'sd20000);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            sane    = (ph % 3 != 2);
            gaps_on = (ph < RANDOM_PHASES - 2);
            pos     = vec_t'({$urandom, $urandom});
            if (sane) begin
                fwd_axis = $urandom_range(0, 2);
                set_camera(pos, axis_vec((fwd_axis + 1) % 3, $urandom_range(0, 1)),
                           axis_vec((fwd_axis + 2) % 3, $urandom_range(0, 1)),
                           axis_vec(fwd_axis, $urandom_range(0, 1)),
                           vec_t'(({$urandom, $urandom} & ~48'h7FFF)
                                  | 48'($urandom_range(0, 600))));
            end
            else begin
                set_camera(pos, vec_t'({$urandom, $urandom}), vec_t'({$urandom, $urandom}),
                           vec_t'({$urandom, $urandom}), vec_t'({$urandom, $urandom}));
            end
            repeat (POINTS_PER_PHASE) send_random_point();
            drain();
        end

        repeat (PIPE_LAT + 8) @(posedge clk);

        $display("Projected %0d points under %0d camera settings, with sender gaps",
                 points_sent, settings_used);
        $display("and axis-aligned, skewed, zero-near and max-near cameras.");
        if (pending != 0)
            $display("%0t: %0d results never arrived", $time, pending);
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
design/vpp_pkg.sv
design/vpp_xform.sv
design/vpp_prep.sv
design/vpp_div.sv
design/vertex_perspective_projection.sv
tb/pixel_checker.sv
tb/vertex_perspective_projection_test.sv
